// ===== rtl/nipt_pkg.sv =====
// Shared constants, codes and types for the note interval pairing table.
package nipt_pkg;

   // Default sizing of the key table and queues
   localparam int DEF_CHANNELS    = 16;
   localparam int DEF_NOTES       = 128;
   localparam int DEF_QUEUE_DEPTH = 8;
   localparam int DEF_TIME_WIDTH  = 32;

   // Fixed port widths
   localparam int CHAN_W   = 4;
   localparam int NOTE_W   = 7;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;

   // Request kinds
   typedef enum logic {
      REQ_START = 1'b0,
      REQ_END   = 1'b1
   } req_kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_INTERVAL = 2'd0,
      STS_NO_START = 2'd1,
      STS_FULL     = 2'd2
   } status_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

endpackage

// ===== rtl/nipt_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module nipt_ram
   import nipt_pkg::*;
#(
   parameter int WIDTH = TIME_W,
   parameter int DEPTH = DEF_CHANNELS * DEF_NOTES,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/note_interval_pairing_table.sv =====
// Top level: pairs note start and end requests into intervals per (channel, note) key.
//
//   Port group | Direction | Handshake          | Carries
//   req_*      | in        | req_valid/req_stall | kind, channel, note, time stamp
//   rsp_*      | out       | rsp_valid/rsp_stall | status, begin, end, note, channel
//
// A start request goes through ST_LOOK, and on to ST_EMIT when the queue is full
// and a result is emitted; an end request goes through ST_LOOK and ST_EMIT when
// the queue is empty and through ST_LOOK, ST_FETCH and ST_EMIT when a start time
// is fetched; the pointer RAM and the time RAM both have a registered read port.
// A result waits in the output register, so the next request is taken while it
// is stalled; only a second result waits for the first to leave. After reset a
// clearing pass writes every pointer entry with req_stall high. Requests with an
// out-of-range key are taken and dropped.
module note_interval_pairing_table
   import nipt_pkg::*;
#(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int NOTES       = DEF_NOTES,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [CHAN_W-1:0]   req_chan,
   input  logic [NOTE_W-1:0]   req_note_num,
   input  logic [TIME_W-1:0]   req_event_time,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TIME_W-1:0]   rsp_begin_time,
   output logic [TIME_W-1:0]   rsp_end_time,
   output logic [NOTE_W-1:0]   rsp_out_note,
   output logic [CHAN_W-1:0]   rsp_out_chan
);

   localparam int KEY_COUNT = CHANNELS * NOTES;
   localparam int KW  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int PW  = CW + SW;
   localparam int SLOTS = KEY_COUNT * QUEUE_DEPTH;
   localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW  = (TIME_WIDTH < TIME_W) ? TIME_WIDTH : TIME_W;

   // Control and held request
   state_type         state_ff, state_in;
   logic [KW-1:0]     clr_ff, clr_in;
   logic              kind_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [NOTE_W-1:0] note_ff;
   logic [TW-1:0]     time_ff;
   logic [KW-1:0]     key_ff;
   logic [1:0]        pend_status_ff, pend_status_in;
   logic [TW-1:0]     pend_begin_ff, pend_begin_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TIME_W-1:0]   rsp_begin_ff;
   logic [TIME_W-1:0]   rsp_end_ff;
   logic [NOTE_W-1:0]   rsp_note_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;

   // RAM ports
   logic           ptr_wr_en, ptr_rd_en;
   logic [KW-1:0]  ptr_wr_addr;
   logic [PW-1:0]  ptr_wr_data, ptr_rd_data;
   logic           st_wr_en, st_rd_en;
   logic [SAW-1:0] st_wr_addr, st_rd_addr;
   logic [TW-1:0]  st_rd_data;

   // Decode of the incoming request and the fetched pointers
   logic           req_take, key_ok, out_free;
   logic [KW-1:0]  key_in;
   logic [SW-1:0]  head_raw, head, head_next, tail;
   logic [CW-1:0]  cnt;
   logic [CW:0]    tail_sum;
   logic [SW:0]    head_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign key_ok    = (32'(req_chan) < 32'(CHANNELS)) && (32'(req_note_num) < 32'(NOTES));
   assign key_in    = KW'(32'(req_chan) * 32'(NOTES) + 32'(req_note_num));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Split the pointer word and work out the ring slots
   always_comb begin
      head_raw = ptr_rd_data[SW-1:0];
      cnt      = ptr_rd_data[PW-1:SW];
      head     = (32'(head_raw) >= 32'(QUEUE_DEPTH)) ? '0 : head_raw;
      tail_sum = (CW+1)'(head) + (CW+1)'(cnt);
      tail     = (32'(tail_sum) >= 32'(QUEUE_DEPTH))
                 ? SW'(32'(tail_sum) - 32'(QUEUE_DEPTH)) : SW'(tail_sum);
      head_sum = (SW+1)'(head) + (SW+1)'(1);
      head_next = (32'(head_sum) >= 32'(QUEUE_DEPTH)) ? '0 : SW'(head_sum);
   end

   // Sequencer: clear, accept, look up pointers, fetch, emit
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      pend_status_in = pend_status_ff;
      pend_begin_in  = pend_begin_ff;
      ptr_rd_en      = 1'b0;
      ptr_wr_en      = 1'b0;
      ptr_wr_addr    = key_ff;
      ptr_wr_data    = '0;
      st_wr_en       = 1'b0;
      st_rd_en       = 1'b0;
      st_wr_addr     = SAW'(32'(key_ff) * 32'(QUEUE_DEPTH) + 32'(tail));
      st_rd_addr     = SAW'(32'(key_ff) * 32'(QUEUE_DEPTH) + 32'(head));
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            ptr_wr_en   = 1'b1;
            ptr_wr_addr = clr_ff;
            clr_in      = clr_ff + KW'(1);
            if (clr_ff == KW'(KEY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && key_ok) begin
               ptr_rd_en = 1'b1;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            pend_begin_in = '0;
            if (kind_ff == REQ_START) begin
               if (32'(cnt) >= 32'(QUEUE_DEPTH)) begin
                  pend_status_in = STS_FULL;
                  state_in       = ST_EMIT;
               end else begin
                  // append the time at the tail slot
                  st_wr_en    = 1'b1;
                  ptr_wr_en   = 1'b1;
                  ptr_wr_data = {cnt + CW'(1), head};
                  state_in    = ST_IDLE;
               end
            end else begin
               if (cnt == '0) begin
                  pend_status_in = STS_NO_START;
                  state_in       = ST_EMIT;
               end else begin
                  // pop the oldest slot
                  st_rd_en       = 1'b1;
                  ptr_wr_en      = 1'b1;
                  ptr_wr_data    = {cnt - CW'(1), head_next};
                  pend_status_in = STS_INTERVAL;
                  state_in       = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            pend_begin_in = st_rd_data;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted request and pending result
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_type;
         chan_ff <= req_chan;
         note_ff <= req_note_num;
         time_ff <= req_event_time[TW-1:0];
         key_ff  <= key_in;
      end
      pend_status_ff <= pend_status_in;
      pend_begin_ff  <= pend_begin_in;
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_status_ff <= pend_status_ff;
         rsp_begin_ff  <= TIME_W'(pend_begin_ff);
         rsp_end_ff    <= TIME_W'(time_ff);
         rsp_note_ff   <= note_ff;
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_begin_time = rsp_begin_ff;
   assign rsp_end_time   = rsp_end_ff;
   assign rsp_out_note   = rsp_note_ff;
   assign rsp_out_chan   = rsp_chan_ff;

   // Per-key count and oldest slot
   nipt_ram #(
      .WIDTH (PW),
      .DEPTH (KEY_COUNT),
      .AW    (KW)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data),
      .rd_en   (ptr_rd_en),
      .rd_addr (key_in),
      .rd_data (ptr_rd_data)
   );

   // Queued start times
   nipt_ram #(
      .WIDTH (TW),
      .DEPTH (SLOTS),
      .AW    (SAW)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (time_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

endmodule

// ===== test/tb_note_interval_pairing_table.sv =====
// Testbench for the note interval pairing table: directed and random request traffic.
module tb_note_interval_pairing_table
   import nipt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS    = DEF_CHANNELS;
   localparam int NOTES       = DEF_NOTES;
   localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam int KEYS        = CHANNELS * NOTES;
   localparam int IDLE_LIMIT  = 6000;   // covers the clearing pass after reset
   localparam int TAIL_CYCLES = 10;

   typedef struct packed {
      status_type        status;
      logic [TIME_W-1:0] begin_time;
      logic [TIME_W-1:0] end_time;
      logic [NOTE_W-1:0] note;
      logic [CHAN_W-1:0] chan;
   } interval_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [CHAN_W-1:0]   req_chan;
   logic [NOTE_W-1:0]   req_note_num;
   logic [TIME_W-1:0]   req_event_time;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [TIME_W-1:0]   rsp_begin_time;
   logic [TIME_W-1:0]   rsp_end_time;
   logic [NOTE_W-1:0]   rsp_out_note;
   logic [CHAN_W-1:0]   rsp_out_chan;

   // Shadow copy of the per-key start-time queues
   logic [TIME_W-1:0] start_times [KEYS][QUEUE_DEPTH];
   int unsigned       queued_count [KEYS];
   int unsigned       head_slot [KEYS];

   interval_type pending_intervals [$];
   int        error_count = 0;
   bit        steady = 0;      // no gaps on either side while set
   int        stall_left = 0;
   int        idle_cycles = 0;

   // Key pool for the random traffic
   logic [CHAN_W-1:0] pool_chan [16];
   logic [NOTE_W-1:0] pool_note [16];

   note_interval_pairing_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_chan       (req_chan),
      .req_note_num   (req_note_num),
      .req_event_time (req_event_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_begin_time (rsp_begin_time),
      .rsp_end_time   (rsp_end_time),
      .rsp_out_note   (rsp_out_note),
      .rsp_out_chan   (rsp_out_chan)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Update the shadow queues and queue the result the request causes
   function automatic void pair_event(req_kind_type kind, logic [CHAN_W-1:0] ch,
                                      logic [NOTE_W-1:0] note, logic [TIME_W-1:0] t);
      interval_type res;
      int unsigned key;
      int unsigned cnt;
      int unsigned slot;
      if (ch >= CHANNELS || note >= NOTES) return;
      key = ch * NOTES + note;
      cnt = queued_count[key];
      slot = head_slot[key];
      res.note = note;
      res.chan = ch;
      res.end_time = t;
      res.begin_time = '0;
      if (kind == REQ_START) begin
         if (cnt >= QUEUE_DEPTH) begin
            res.status = STS_FULL;
            pending_intervals.push_back(res);
         end else begin
            start_times[key][(slot + cnt) % QUEUE_DEPTH] = t;
            queued_count[key] = cnt + 1;
         end
      end else if (cnt == 0) begin
         res.status = STS_NO_START;
         pending_intervals.push_back(res);
      end else begin
         res.status = STS_INTERVAL;
         res.begin_time = start_times[key][slot];
         pending_intervals.push_back(res);
         head_slot[key] = (slot + 1) % QUEUE_DEPTH;
         queued_count[key] = cnt - 1;
      end
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request, hold it until accepted, then idle for a random gap
   task automatic send_event(req_kind_type kind, logic [CHAN_W-1:0] ch,
                             logic [NOTE_W-1:0] note, logic [TIME_W-1:0] t);
      int gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_chan       <= ch;
      req_note_num   <= note;
      req_event_time <= t;
      do @(posedge clock); while (req_stall !== 1'b0);
      pair_event(kind, ch, note, t);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid so a held request is not taken twice
   task automatic idle_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      idle_request();
      while (pending_intervals.size() != 0) @(posedge clock);
   endtask

   // Fill one key past its depth, then drain it past empty
   task automatic test_fill_and_drain();
      logic [TIME_W-1:0] t;
      send_event(REQ_END, 4'd0, 7'd0, 32'h0000_0010);
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         case (i)
            0: t = 32'h0000_0000;
            1: t = 32'hFFFF_FFFF;
            2: t = 32'hAAAA_AAAA;
            3: t = 32'h5555_5555;
            default: t = $urandom;
         endcase
         send_event(REQ_START, 4'd0, 7'd0, t);
      end
      for (int i = 0; i <= QUEUE_DEPTH; i++)
         send_event(REQ_END, 4'd0, 7'd0, $urandom);
   endtask

   // Highest key and extreme time stamps
   task automatic test_extreme_keys();
      send_event(REQ_START, 4'hF, 7'h7F, 32'hFFFF_FFFF);
      send_event(REQ_END, 4'hF, 7'h7F, 32'h0000_0000);
      send_event(REQ_START, 4'hA, 7'h55, 32'h5555_5555);
      send_event(REQ_END, 4'h5, 7'h2A, 32'hAAAA_AAAA);
      send_event(REQ_END, 4'hA, 7'h55, 32'hAAAA_AAAA);
   endtask

   // Random requests over a small key pool with some requests on any key
   task automatic test_random_traffic(int count, int keys, int start_pct);
      int                sel;
      int                r;
      req_kind_type      kind;
      logic [CHAN_W-1:0] ch;
      logic [NOTE_W-1:0] note;
      logic [TIME_W-1:0] t;
      for (int i = 0; i < keys; i++) begin
         pool_chan[i] = CHAN_W'($urandom);
         pool_note[i] = NOTE_W'($urandom);
      end
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 99) < start_pct) ? REQ_START : REQ_END;
         if ($urandom_range(0, 9) == 0) begin
            ch = CHAN_W'($urandom);
            note = NOTE_W'($urandom);
         end else begin
            sel = $urandom_range(0, keys - 1);
            ch = pool_chan[sel];
            note = pool_note[sel];
         end
         r = $urandom_range(0, 19);
         t = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         send_event(kind, ch, note, t);
      end
   endtask

   // Hold off the sender until every result has arrived
   task automatic test_drain_pause();
      wait_drained();
      repeat ($urandom_range(2, 12)) @(posedge clock);
   endtask

   // Result side stall pattern
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // Compare each accepted result with the oldest expected interval
   always @(posedge clock) begin
      interval_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_intervals.size() == 0) begin
            $error("unexpected result: status %0d end_time %h", rsp_status, rsp_end_time);
            error_count++;
         end else begin
            exp_res = pending_intervals.pop_front();
            if (rsp_status !== exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_begin_time !== exp_res.begin_time) begin
               $error("begin_time: expected %h, actual %h", exp_res.begin_time,
                      rsp_begin_time);
               error_count++;
            end
            if (rsp_end_time !== exp_res.end_time) begin
               $error("end_time: expected %h, actual %h", exp_res.end_time, rsp_end_time);
               error_count++;
            end
            if (rsp_out_note !== exp_res.note) begin
               $error("out_note: expected %0d, actual %0d", exp_res.note, rsp_out_note);
               error_count++;
            end
            if (rsp_out_chan !== exp_res.chan) begin
               $error("out_chan: expected %0d, actual %0d", exp_res.chan, rsp_out_chan);
               error_count++;
            end
         end
      end
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = 1'b0;
      req_chan       = '0;
      req_note_num   = '0;
      req_event_time = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_and_drain();
      test_extreme_keys();
      test_random_traffic(450, 4, 65);
      test_drain_pause();
      test_random_traffic(350, 4, 35);
      steady = 1;
      test_random_traffic(300, 12, 50);
      steady = 0;
      test_drain_pause();
      test_random_traffic(250, 2, 55);
      test_random_traffic(150, 16, 50);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_intervals.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
